>>> sv/lmbs_pkg.sv
// Shared constants, command type and helper functions for the LED matrix bit-plane scanner.
package lmbs_pkg;

  localparam int ROWS   = 16;
  localparam int PLANES = 8;
  localparam int SHIFT  = 32;

  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W    = $clog2(SHIFT + 1);
  localparam int ADDR_W   = 12;
  localparam int WORD_W   = 16;
  localparam int PRESC_W  = 8;
  localparam int OPRESC_W = 7;
  localparam int CHUNK_W  = 7;
  localparam int ROW_POS  = 11;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [WORD_W-1:0]  PIN_LATCH    = WORD_W'(1 << 9);
  localparam logic [WORD_W-1:0]  PIN_OE       = WORD_W'(1 << 10);
  localparam logic [PRESC_W-1:0] PRESC_RELOAD = PRESC_W'((1 << PLANES) - 1);

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // One queued job: a store write, or a tick carrying its precomputed scan values.
  typedef struct packed {
    logic                is_write;
    logic [ADDR_W-1:0]   addr;   // write address, or chunk base address for a tick
    logic [WORD_W-1:0]   word;   // write data, or row bits for a tick
    logic [OPRESC_W-1:0] presc;  // display prescale for a tick
  } cmd_t;

  function automatic logic [WORD_W-1:0] row_word(input logic [ROW_W-1:0] row);
    logic [31:0] tmp;
    tmp = 32'(row) << ROW_POS;
    return tmp[WORD_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] chunk_base(input logic [CHUNK_W-1:0] chunk);
    logic [31:0] prod;
    prod = 32'(chunk) * 32'(SHIFT);
    return prod[ADDR_W-1:0];
  endfunction

endpackage

>>> sv/led_matrix_bitplane_scanner.sv
// Top level of the LED matrix bit-plane scanner: front end, command queue and back end.
//
// Usage: the input channel (in_valid/in_ready) carries one item per handshake. An item with
// in_req_type set stores in_write_data in the 4096-word frame store at in_write_address and
// produces no output. An item with in_req_type clear is a display tick: it produces one latch
// word, SHIFT data words (frame store words of the current chunk ORed with the latched row and
// flagged with out_clock_pulse), and a final output-enable word flagged with out_last that
// carries out_display_prescale. Results leave on out_valid/out_ready, one item per handshake.
// The front end advances the row, prescale and chunk counters as each tick is accepted and
// pushes a command into a two-entry queue, so it keeps accepting while the back end works.
// With the queue and back end idle, an accepted tick passes the queue, the sequencer's latch
// state and the output register before its latch word is valid. The single frame store read
// port delivers one data word per cycle while the receiver keeps taking words; a write is
// stored as it is popped. The back end pops a new command only when idle, after loading the
// final word of a tick. When the receiver stalls, the output register holds its item and the
// sequencer and the pending frame store read wait; the queue then fills and in_ready drops.
// Reset (synchronous, active low) empties the queue, idles the sequencer, sets the row counter
// to ROWS - 1 and clears prescale and chunk. The frame store is not cleared and must be
// written before it is displayed.
module led_matrix_bitplane_scanner import lmbs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [ADDR_W-1:0]   in_write_address,
  input  logic [WORD_W-1:0]   in_write_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WORD_W-1:0]   out_port_word,
  output logic                out_clock_pulse,
  output logic [OPRESC_W-1:0] out_display_prescale,
  output logic                out_last
);

  // Commands flow from the front end through the queue to the back end.
  logic q_push, q_pop, q_full, q_empty;
  cmd_t push_cmd, head_cmd;

  lmbs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_write_address (in_write_address),
    .in_write_data    (in_write_data),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (push_cmd)
  );

  lmbs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  lmbs_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_head               (head_cmd),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_port_word        (out_port_word),
    .out_clock_pulse      (out_clock_pulse),
    .out_display_prescale (out_display_prescale),
    .out_last             (out_last)
  );

  // Once the final word of a tick is taken, no data word can follow in the next cycle.
  a_no_data_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !(out_valid && out_clock_pulse))
    else $error("data word directly after final word");

  // A word that is neither data nor final is the latch word and drives latch and enable.
  a_latch_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_clock_pulse && !out_last |-> out_port_word[9] && out_port_word[10])
    else $error("latch word lacks latch or enable");

  // The back end never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

>>> sv/lmbs_front.sv
// Front end: accepts items, keeps the scan counters and builds queue commands.
module lmbs_front import lmbs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [ADDR_W-1:0]   in_write_address,
  input  logic [WORD_W-1:0]   in_write_data,
  input  logic                q_full,
  output logic                q_push,
  output cmd_t                q_cmd
);

  logic [ROW_W-1:0]   row_r,   row_nxt;
  logic [PRESC_W-1:0] presc_r, presc_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [ROW_W:0]     row_inc;
  logic [PRESC_W-1:0] presc_base;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign row_inc  = {1'b0, row_r} + (ROW_W+1)'(1);

  always_comb begin
    row_nxt    = row_r;
    chunk_nxt  = chunk_r + CHUNK_W'(1);
    presc_base = presc_r;
    if (presc_r == '0) begin
      presc_base = PRESC_RELOAD;
      if (row_inc >= (ROW_W+1)'(ROWS)) begin
        row_nxt   = '0;
        chunk_nxt = '0;
      end else begin
        row_nxt = row_inc[ROW_W-1:0];
      end
    end
    presc_nxt = presc_base >> 1;
  end

  always_comb begin
    if (in_req_type == REQ_WRITE) begin
      q_cmd.is_write = 1'b1;
      q_cmd.addr     = in_write_address;
      q_cmd.word     = in_write_data;
      q_cmd.presc    = '0;
    end else begin
      q_cmd.is_write = 1'b0;
      q_cmd.addr     = chunk_base(chunk_nxt);
      q_cmd.word     = row_word(row_r);
      q_cmd.presc    = presc_nxt[OPRESC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= ROW_W'(ROWS - 1);
      presc_r <= '0;
      chunk_r <= '0;
    end else if (q_push && in_req_type == REQ_TICK) begin
      row_r   <= row_nxt;
      presc_r <= presc_nxt;
      chunk_r <= chunk_nxt;
    end
  end

endmodule

>>> sv/lmbs_queue.sv
// Short command queue between the front end and the back end.
module lmbs_queue import lmbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = q_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) return '0;
    return p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

endmodule

>>> sv/lmbs_back.sv
// Back end: frame store, tick sequencer and output register.
module lmbs_back import lmbs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  cmd_t                q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WORD_W-1:0]   out_port_word,
  output logic                out_clock_pulse,
  output logic [OPRESC_W-1:0] out_display_prescale,
  output logic                out_last
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LATCH = 2'd1;
  localparam logic [1:0] S_DATA  = 2'd2;
  localparam logic [1:0] S_END   = 2'd3;

  logic [WORD_W-1:0]   mem [1 << ADDR_W];
  logic [WORD_W-1:0]   rd_data_r;

  logic [1:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [WORD_W-1:0]   row_bits_r;
  logic [OPRESC_W-1:0] presc_r;
  logic [CNT_W-1:0]    issue_cnt_r, issue_cnt_nxt;
  logic [CNT_W-1:0]    send_cnt_r, send_cnt_nxt;
  logic                rd_vld_r, rd_vld_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_word_r;
  logic                out_clk_r;
  logic [OPRESC_W-1:0] out_presc_r;
  logic                out_last_r;

  logic                out_free, consume, issue, mem_we, load;
  logic [WORD_W-1:0]   load_word;
  logic                load_clk, load_last;
  logic [OPRESC_W-1:0] load_presc;
  logic [ADDR_W-1:0]   rd_addr;

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign mem_we   = q_pop && q_head.is_write;
  assign consume  = (state_r == S_DATA) && rd_vld_r && out_free;
  assign issue    = ((state_r == S_LATCH) || (state_r == S_DATA)) &&
                    (issue_cnt_r < CNT_W'(SHIFT)) && (!rd_vld_r || consume);
  assign rd_addr  = base_r + ADDR_W'(issue_cnt_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_head.addr] <= q_head.word;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    issue_cnt_nxt = issue ? issue_cnt_r + CNT_W'(1) : issue_cnt_r;
    send_cnt_nxt  = consume ? send_cnt_r + CNT_W'(1) : send_cnt_r;
    rd_vld_nxt    = issue ? 1'b1 : (consume ? 1'b0 : rd_vld_r);
    load          = 1'b0;
    load_word     = '0;
    load_clk      = 1'b0;
    load_presc    = '0;
    load_last     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_pop && !q_head.is_write) begin
          state_nxt     = S_LATCH;
          issue_cnt_nxt = '0;
          send_cnt_nxt  = '0;
        end
      end
      S_LATCH: begin
        if (out_free) begin
          load      = 1'b1;
          load_word = PIN_OE | PIN_LATCH | row_bits_r;
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        if (consume) begin
          load      = 1'b1;
          load_word = row_bits_r | rd_data_r;
          load_clk  = 1'b1;
          if (send_cnt_r == CNT_W'(SHIFT - 1)) begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        if (out_free) begin
          load       = 1'b1;
          load_word  = PIN_OE;
          load_presc = presc_r;
          load_last  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_cnt_r <= '0;
      send_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      send_cnt_r  <= send_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_head.is_write) begin
      base_r     <= q_head.addr;
      row_bits_r <= q_head.word;
      presc_r    <= q_head.presc;
    end
    if (load) begin
      out_word_r  <= load_word;
      out_clk_r   <= load_clk;
      out_presc_r <= load_presc;
      out_last_r  <= load_last;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_port_word        = out_word_r;
  assign out_clock_pulse      = out_clk_r;
  assign out_display_prescale = out_presc_r;
  assign out_last             = out_last_r;

endmodule
